// ----- hdl/gbs_cdt_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_cdt_pkg
// Types and the distribution table for the CDT base Gaussian sampler.
// ----------------------------------------------------------------------------
package gbs_cdt_pkg;

	localparam int LimbW    = 24;
	localparam int TableLen = 18;
	localparam int CountW   = 5;   // holds 0 .. TableLen
	localparam int GroupLen = 6;   // entries per partial count
	localparam int Groups   = TableLen / GroupLen;
	localparam int GroupW   = 3;   // holds 0 .. GroupLen
	localparam int SampleW  = 6;
	localparam int SquareW  = 9;

	// Entries as {high limb, middle limb, low limb}, in falling order.
	localparam logic [3*LimbW-1:0] CDT_TABLE [TableLen] = '{
		{24'd10745844, 24'd3068844,  24'd3741698},
		{24'd5559083,  24'd1580863,  24'd8248194},
		{24'd2260429,  24'd13669192, 24'd2736639},
		{24'd708981,   24'd4421575,  24'd10046180},
		{24'd169348,   24'd7122675,  24'd4136815},
		{24'd30538,    24'd13063405, 24'd7650655},
		{24'd4132,     24'd14505003, 24'd7826148},
		{24'd417,      24'd16768101, 24'd11363290},
		{24'd31,       24'd8444042,  24'd8086568},
		{24'd1,        24'd12844466, 24'd265321},
		{24'd0,        24'd1232676,  24'd13644283},
		{24'd0,        24'd38047,    24'd9111839},
		{24'd0,        24'd870,      24'd6138264},
		{24'd0,        24'd14,       24'd12545723},
		{24'd0,        24'd0,        24'd3104126},
		{24'd0,        24'd0,        24'd28824},
		{24'd0,        24'd0,        24'd198},
		{24'd0,        24'd0,        24'd1}
	};

	typedef struct packed {
		logic [LimbW-1:0] rand_low;
		logic [LimbW-1:0] rand_mid;
		logic [LimbW-1:0] rand_high;
		logic             sign_bit;
	} sample_req_t;

	typedef struct packed {
		logic signed [SampleW-1:0] bimodal_sample;
		logic        [SquareW-1:0] magnitude_square;
	} sample_rsp_t;

	// Per-limb compare flags for one table entry.
	typedef struct packed {
		logic lt_high;
		logic eq_high;
		logic lt_mid;
		logic eq_mid;
		logic lt_low;
	} limb_cmp_t;

endpackage

// ----- hdl/gaussian_base_sampler_cdt_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_base_sampler_cdt_unit
// Half-Gaussian CDT sampler: counts table entries above a 72-bit value and
// returns the bimodal sample and the square of the count.
// ----------------------------------------------------------------------------
// An item passes the compare, group-count, full-count and output registers.
// Throughput: one item per cycle; busy stays low, every stage advances each
// cycle and no result is held back.
// Reset: arst_n clears all stage valid bits; payload registers are not reset.
module gaussian_base_sampler_cdt_unit
	import gbs_cdt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sample_req_t operand,
	output logic        done,
	output sample_rsp_t result
);

	// Stage 1: per-limb compares against every entry
	logic      valid_s1;
	logic      sign_s1;
	limb_cmp_t cmp_s1 [TableLen];

	// Stage 2: borrow bits resolved and counted in groups
	logic              valid_s2;
	logic              sign_s2;
	logic [GroupW-1:0] part_s2 [Groups];

	// Stage 3: full count
	logic              valid_s3;
	logic              sign_s3;
	logic [CountW-1:0] z_s3;

	// Stage 4: output register
	logic        valid_s4;
	sample_rsp_t rsp_s4;

	limb_cmp_t         cmp_d [TableLen];
	logic [GroupW-1:0] part_d [Groups];
	logic [CountW-1:0] z_d;
	sample_rsp_t       rsp_d;
	logic              accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		for (int i = 0; i < TableLen; i++) begin
			cmp_d[i].lt_high = operand.rand_high <  CDT_TABLE[i][3*LimbW-1:2*LimbW];
			cmp_d[i].eq_high = operand.rand_high == CDT_TABLE[i][3*LimbW-1:2*LimbW];
			cmp_d[i].lt_mid  = operand.rand_mid  <  CDT_TABLE[i][2*LimbW-1:LimbW];
			cmp_d[i].eq_mid  = operand.rand_mid  == CDT_TABLE[i][2*LimbW-1:LimbW];
			cmp_d[i].lt_low  = operand.rand_low  <  CDT_TABLE[i][LimbW-1:0];
		end
	end

	// Resolve the borrow chain per entry, then count six entries per group.
	always_comb begin
		logic br;
		for (int g = 0; g < Groups; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < GroupLen; k++) begin
				br = cmp_s1[g*GroupLen+k].lt_high ||
					(cmp_s1[g*GroupLen+k].eq_high &&
					 (cmp_s1[g*GroupLen+k].lt_mid ||
					  (cmp_s1[g*GroupLen+k].eq_mid && cmp_s1[g*GroupLen+k].lt_low)));
				part_d[g] = part_d[g] + GroupW'(br);
			end
		end
	end

	always_comb begin
		z_d = '0;
		for (int g = 0; g < Groups; g++) begin
			z_d = z_d + CountW'(part_s2[g]);
		end
	end

	always_comb begin
		logic [SquareW-1:0] z_wide;
		z_wide = SquareW'(z_s3);
		if (sign_s3) begin
			rsp_d.bimodal_sample = SampleW'(z_s3) + SampleW'(1);
		end else begin
			rsp_d.bimodal_sample = SampleW'(0) - SampleW'(z_s3);
		end
		rsp_d.magnitude_square = z_wide * z_wide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Payload advances every cycle; valid bits mark what counts.
	always_ff @(posedge clk) begin
		cmp_s1  <= cmp_d;
		sign_s1 <= operand.sign_bit;
		part_s2 <= part_d;
		sign_s2 <= sign_s1;
		z_s3    <= z_d;
		sign_s3 <= sign_s2;
		rsp_s4  <= rsp_d;
	end

	assign done   = valid_s4;
	assign result = rsp_s4;

	a_start_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted item did not complete after four cycles");

	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result strobe without a matching accepted item");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> z_s3 <= CountW'(TableLen))
		else $error("entry count exceeds table length");

	a_square_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.magnitude_square <= SquareW'(TableLen * TableLen))
		else $error("square out of range");

endmodule
